FILE: rtl/core/ple_pkg.sv
// Shared types, constants and codes for the positional list engine.
package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 6;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_POS   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LIST      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_DEL_POS   = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOW,
        CELL_FROM_HIGH
    } cell_op_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic [STAT_W-1:0]        status;
        logic                     last;
        logic [LEN_W-1:0]         length;
    } result_t;

endpackage

FILE: rtl/core/ple_cell.sv
// One storage cell of the list chain: holds an element, loads or takes a neighbor's.
module ple_cell (
    input  logic                             clk,
    input  ple_pkg::cell_op_t                op,
    input  logic signed [ple_pkg::DATA_W-1:0] load_data,
    input  logic signed [ple_pkg::DATA_W-1:0] low_data,
    input  logic signed [ple_pkg::DATA_W-1:0] high_data,
    output logic signed [ple_pkg::DATA_W-1:0] data
);

    logic signed [ple_pkg::DATA_W-1:0] data_reg;
    logic signed [ple_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        case (op)
            ple_pkg::CELL_LOAD:      data_next = load_data;
            ple_pkg::CELL_FROM_LOW:  data_next = low_data;
            ple_pkg::CELL_FROM_HIGH: data_next = high_data;
            default:                 data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: rtl/core/positional_list_engine_core.sv
// Top level: bounded ordered list held in a chain of cells, with command control.
//
// Every transaction other than a list-all of a non-empty list gives a single result:
// the result strobe (done) is high in the cycle right after start is taken, and busy
// stays low, so a new command can follow at once. This covers inserts, deletes, error
// answers and the list-all of an empty list. A list-all on a list of N elements
// rotates the cell chain one place per cycle; busy is high while it rotates. The N
// results follow through the result register, one per cycle. The last one carries
// last = 1 and shows in the cycle after busy falls, when the next command may already
// be taken. Every result is shown for one cycle only and is not held for the receiver.
module positional_list_engine_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ple_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output ple_pkg::result_t result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } state_t;

    state_t                       state_reg, state_next;
    logic [ple_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [ple_pkg::CNT_W-1:0]    rem_reg, rem_next;
    logic                         done_reg, done_next;
    ple_pkg::result_t             result_reg, result_next;

    ple_pkg::cell_op_t                 cell_op   [ple_pkg::CAPACITY];
    logic signed [ple_pkg::DATA_W-1:0] cell_data [ple_pkg::CAPACITY];
    logic signed [ple_pkg::DATA_W-1:0] load_data;

    logic [ple_pkg::CMP_W-1:0] cnt_ext;
    logic [ple_pkg::CMP_W-1:0] pos_ext;
    logic [ple_pkg::CMP_W-1:0] idx;
    logic [ple_pkg::CMP_W-1:0] last_idx;
    logic                      do_ins;
    logic                      do_del;
    logic                      do_rot;
    logic                      full;
    logic                      empty;

    genvar g;
    generate
        for (g = 0; g < ple_pkg::CAPACITY; g++)
        begin : g_cell
            logic signed [ple_pkg::DATA_W-1:0] low_d;
            logic signed [ple_pkg::DATA_W-1:0] high_d;
            if (g == 0)
            begin : g_first
                assign low_d = '0;
            end
            else
            begin : g_mid_low
                assign low_d = cell_data[g-1];
            end
            if (g == ple_pkg::CAPACITY - 1)
            begin : g_end
                assign high_d = '0;
            end
            else
            begin : g_mid_high
                assign high_d = cell_data[g+1];
            end
            ple_cell u_cell (
                .clk       (clk),
                .op        (cell_op[g]),
                .load_data (load_data),
                .low_data  (low_d),
                .high_data (high_d),
                .data      (cell_data[g])
            );
        end
    endgenerate

    assign cnt_ext  = ple_pkg::CMP_W'(count_reg);
    assign pos_ext  = ple_pkg::CMP_W'(cmd.position);
    assign full     = (count_reg == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
    assign empty    = (count_reg == '0);
    assign last_idx = cnt_ext - ple_pkg::CMP_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        done_next   = 1'b0;
        result_next = '{value_res: '0, status: ple_pkg::ST_OK, last: 1'b1, length: '0};
        load_data   = cmd.value;
        idx         = '0;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        do_rot      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    unique case (cmd.func) inside
                        ple_pkg::FN_INS_FRONT, ple_pkg::FN_INS_BACK, ple_pkg::FN_INS_POS:
                        begin
                            if (full)
                            begin
                                result_next.status = ple_pkg::ST_FULL;
                            end
                            else if (cmd.func == ple_pkg::FN_INS_FRONT)
                            begin
                                do_ins = 1'b1;
                            end
                            else if (cmd.func == ple_pkg::FN_INS_BACK)
                            begin
                                idx    = cnt_ext;
                                do_ins = 1'b1;
                            end
                            else if (pos_ext == '0 || pos_ext > cnt_ext + ple_pkg::CMP_W'(1))
                            begin
                                result_next.status = ple_pkg::ST_RANGE;
                            end
                            else
                            begin
                                idx    = pos_ext - ple_pkg::CMP_W'(1);
                                do_ins = 1'b1;
                            end
                        end
                        ple_pkg::FN_LIST:
                        begin
                            if (empty)
                            begin
                                result_next.status = ple_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                rem_next   = count_reg;
                                state_next = S_LIST;
                            end
                        end
                        ple_pkg::FN_DEL_FRONT, ple_pkg::FN_DEL_BACK, ple_pkg::FN_DEL_POS:
                        begin
                            if (empty)
                            begin
                                result_next.status = ple_pkg::ST_EMPTY;
                            end
                            else if (cmd.func == ple_pkg::FN_DEL_FRONT)
                            begin
                                do_del = 1'b1;
                            end
                            else if (cmd.func == ple_pkg::FN_DEL_BACK)
                            begin
                                idx    = last_idx;
                                do_del = 1'b1;
                            end
                            else if (pos_ext == '0 || pos_ext > cnt_ext)
                            begin
                                result_next.status = ple_pkg::ST_RANGE;
                            end
                            else
                            begin
                                idx    = pos_ext - ple_pkg::CMP_W'(1);
                                do_del = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LIST:
            begin
                // head goes out, chain rotates so the next element reaches cell 0
                done_next             = 1'b1;
                do_rot                = 1'b1;
                load_data             = cell_data[0];
                result_next.value_res = cell_data[0];
                result_next.last      = (rem_reg == ple_pkg::CNT_W'(1));
                rem_next              = rem_reg - ple_pkg::CNT_W'(1);
                if (rem_reg == ple_pkg::CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_ins)
        begin
            count_next = count_reg + ple_pkg::CNT_W'(1);
        end
        if (do_del)
        begin
            count_next            = count_reg - ple_pkg::CNT_W'(1);
            result_next.value_res = cell_data[idx[ple_pkg::IDX_W-1:0]];
        end
        result_next.length = ple_pkg::LEN_W'(count_next);

        for (int i = 0; i < ple_pkg::CAPACITY; i++)
        begin
            cell_op[i] = ple_pkg::CELL_HOLD;
            if (do_ins)
            begin
                if (ple_pkg::CMP_W'(i) == idx)
                    cell_op[i] = ple_pkg::CELL_LOAD;
                else if (ple_pkg::CMP_W'(i) > idx && ple_pkg::CMP_W'(i) <= cnt_ext)
                    cell_op[i] = ple_pkg::CELL_FROM_LOW;
            end
            else if (do_del)
            begin
                if (ple_pkg::CMP_W'(i) >= idx && ple_pkg::CMP_W'(i) < last_idx)
                    cell_op[i] = ple_pkg::CELL_FROM_HIGH;
            end
            else if (do_rot)
            begin
                if (ple_pkg::CMP_W'(i) == last_idx)
                    cell_op[i] = ple_pkg::CELL_LOAD;
                else if (ple_pkg::CMP_W'(i) < last_idx)
                    cell_op[i] = ple_pkg::CELL_FROM_HIGH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg == S_LIST);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: tb/tb_positional_list_engine_core.sv
// Self-checking testbench for positional_list_engine_core: directed and random list commands.
`timescale 1ns / 100ps

module tb_positional_list_engine_core;

    // Selector 7 has no operation behind it; it still answers once.
    localparam logic [ple_pkg::FUNC_W-1:0] FN_NONE = 3'd7;

    localparam int MAX_GAP    = 6;
    localparam int DRAIN_WAIT = ple_pkg::CAPACITY + 16;

    typedef enum int {
        MIX_BALANCED,
        MIX_GROW,
        MIX_SHRINK
    } op_mix_t;

    // Mirror of the list contents and the results still owed by the block.
    class list_mirror;
        logic signed [ple_pkg::DATA_W-1:0] elems[$];
        ple_pkg::result_t                  pending_results[$];
        int                                errors;

        function new();
            errors = 0;
        endfunction

        function int held();
            return elems.size();
        endfunction

        function int owed();
            return pending_results.size();
        endfunction

        function void note_cmd(ple_pkg::cmd_t c);
            ple_pkg::result_t r;
            int               n;
            int               pos;
            int               i;
            n          = elems.size();
            pos        = int'(c.position);
            r          = '0;
            r.status   = ple_pkg::ST_OK;
            r.last     = 1'b1;
            case (c.func) inside
                ple_pkg::FN_INS_FRONT, ple_pkg::FN_INS_BACK, ple_pkg::FN_INS_POS:
                begin
                    if (n >= ple_pkg::CAPACITY)
                        r.status = ple_pkg::ST_FULL;
                    else if (c.func == ple_pkg::FN_INS_FRONT)
                        elems.push_front(c.value);
                    else if (c.func == ple_pkg::FN_INS_BACK)
                        elems.push_back(c.value);
                    else if (pos < 1 || pos > n + 1)
                        r.status = ple_pkg::ST_RANGE;
                    else
                        elems.insert(pos - 1, c.value);
                end
                ple_pkg::FN_LIST:
                begin
                    if (n == 0)
                        r.status = ple_pkg::ST_EMPTY;
                    else
                    begin
                        for (i = 0; i < n; i++)
                        begin
                            r.value_res = elems[i];
                            r.status    = ple_pkg::ST_OK;
                            r.last      = (i == n - 1);
                            r.length    = ple_pkg::LEN_W'(n);
                            pending_results.push_back(r);
                        end
                        return;
                    end
                end
                ple_pkg::FN_DEL_FRONT, ple_pkg::FN_DEL_BACK, ple_pkg::FN_DEL_POS:
                begin
                    if (n == 0)
                        r.status = ple_pkg::ST_EMPTY;
                    else if (c.func == ple_pkg::FN_DEL_FRONT)
                        r.value_res = elems.pop_front();
                    else if (c.func == ple_pkg::FN_DEL_BACK)
                        r.value_res = elems.pop_back();
                    else if (pos < 1 || pos > n)
                        r.status = ple_pkg::ST_RANGE;
                    else
                    begin
                        r.value_res = elems[pos - 1];
                        elems.delete(pos - 1);
                    end
                end
                default:
                begin
                end
            endcase
            r.length = ple_pkg::LEN_W'(elems.size());
            pending_results.push_back(r);
        endfunction

        function void check_result(ple_pkg::result_t got);
            ple_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction outstanding: value_res %0d status %0d",
                       got.value_res, got.status);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.value_res !== want.value_res)
            begin
                $error("value_res: expected %0d, actual %0d", want.value_res, got.value_res);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
            if (got.length !== want.length)
            begin
                $error("length: expected %0d, actual %0d", want.length, got.length);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    ple_pkg::cmd_t    cmd;
    logic             busy;
    logic             done;
    ple_pkg::result_t result;

    list_mirror mirror;
    bit         gaps_on;

    positional_list_engine_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.check_result(result);
    end

    function automatic ple_pkg::cmd_t make_cmd(logic [ple_pkg::FUNC_W-1:0] f,
                                               logic signed [ple_pkg::DATA_W-1:0] v,
                                               logic [ple_pkg::POS_W-1:0] p);
        ple_pkg::cmd_t c;
        c.func     = f;
        c.value    = v;
        c.position = p;
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic send_cmd(ple_pkg::cmd_t c);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            cmd   <= make_cmd(3'($urandom), $urandom, 6'($urandom));
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        mirror.note_cmd(c);
        @(negedge clk);
    endtask

    function automatic ple_pkg::cmd_t random_cmd(op_mix_t mix, int n);
        int                         roll;
        int                         ins_pct;
        int                         del_pct;
        logic [ple_pkg::FUNC_W-1:0] f;
        logic [ple_pkg::POS_W-1:0]  p;
        case (mix)
            MIX_GROW:
            begin
                ins_pct = 75;
                del_pct = 12;
            end
            MIX_SHRINK:
            begin
                ins_pct = 12;
                del_pct = 75;
            end
            default:
            begin
                ins_pct = 45;
                del_pct = 40;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 3)
            f = FN_NONE;
        else if (roll < 3 + ins_pct)
        begin
            case ($urandom_range(0, 2))
                0:       f = ple_pkg::FN_INS_FRONT;
                1:       f = ple_pkg::FN_INS_BACK;
                default: f = ple_pkg::FN_INS_POS;
            endcase
        end
        else if (roll < 3 + ins_pct + del_pct)
        begin
            case ($urandom_range(0, 2))
                0:       f = ple_pkg::FN_DEL_FRONT;
                1:       f = ple_pkg::FN_DEL_BACK;
                default: f = ple_pkg::FN_DEL_POS;
            endcase
        end
        else
            f = ple_pkg::FN_LIST;
        // Mostly in-range positions, some anywhere in the field.
        if ($urandom_range(0, 99) < 15)
            p = 6'($urandom_range(0, 63));
        else if (f == ple_pkg::FN_INS_POS)
            p = 6'($urandom_range(1, n + 1));
        else
            p = 6'($urandom_range(1, (n > 0) ? n : 1));
        return make_cmd(f, $urandom, p);
    endfunction

    task automatic run_random(op_mix_t mix, int count);
        repeat (count)
            send_cmd(random_cmd(mix, mirror.held()));
    endtask

    initial
    begin
        int guard;
        mirror  = new();
        gaps_on = 1'b1;
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty list answers, then corner cases on short lists of one to three elements.
        send_cmd(make_cmd(ple_pkg::FN_DEL_FRONT, 32'sd5, 6'd1));
        send_cmd(make_cmd(ple_pkg::FN_DEL_BACK, 32'sd5, 6'd1));
        send_cmd(make_cmd(ple_pkg::FN_DEL_POS, 32'sd0, 6'd0));
        send_cmd(make_cmd(ple_pkg::FN_DEL_POS, -32'sd1, 6'd63));
        send_cmd(make_cmd(ple_pkg::FN_LIST, 32'sd7, 6'd1));
        send_cmd(make_cmd(FN_NONE, 32'sd9, 6'd2));
        send_cmd(make_cmd(ple_pkg::FN_INS_BACK, 32'h7fff_ffff, 6'd0));
        send_cmd(make_cmd(ple_pkg::FN_DEL_BACK, 32'sd0, 6'd0));
        send_cmd(make_cmd(ple_pkg::FN_INS_POS, -32'sd1, 6'd1));
        send_cmd(make_cmd(ple_pkg::FN_DEL_POS, 32'sd0, 6'd1));
        send_cmd(make_cmd(ple_pkg::FN_INS_FRONT, 32'h8000_0000, 6'd63));
        send_cmd(make_cmd(ple_pkg::FN_INS_POS, 32'sd3, 6'd0));
        send_cmd(make_cmd(ple_pkg::FN_INS_POS, 32'sd3, 6'd3));
        send_cmd(make_cmd(ple_pkg::FN_INS_POS, 32'sd0, 6'd2));
        send_cmd(make_cmd(ple_pkg::FN_INS_POS, 32'sd1, 6'd1));
        send_cmd(make_cmd(ple_pkg::FN_LIST, 32'sd0, 6'd0));
        send_cmd(make_cmd(ple_pkg::FN_DEL_POS, 32'sd0, 6'd0));
        send_cmd(make_cmd(ple_pkg::FN_DEL_POS, 32'sd0, 6'd4));
        send_cmd(make_cmd(ple_pkg::FN_DEL_POS, 32'sd0, 6'd2));
        send_cmd(make_cmd(FN_NONE, -32'sd1, 6'd63));
        send_cmd(make_cmd(ple_pkg::FN_DEL_FRONT, 32'sd0, 6'd0));
        send_cmd(make_cmd(ple_pkg::FN_LIST, 32'sd0, 6'd0));

        run_random(MIX_BALANCED, 30);

        // Grow to capacity, then hit the full-list cases.
        gaps_on = 1'b0;
        guard   = 0;
        while (mirror.held() < ple_pkg::CAPACITY && guard < 300)
        begin
            send_cmd(random_cmd(MIX_GROW, mirror.held()));
            guard++;
        end
        gaps_on = 1'b1;
        if (mirror.held() == ple_pkg::CAPACITY)
        begin
            send_cmd(make_cmd(ple_pkg::FN_INS_POS, 32'sd11, 6'd63));
            send_cmd(make_cmd(ple_pkg::FN_INS_FRONT, 32'sd12, 6'd1));
            send_cmd(make_cmd(ple_pkg::FN_INS_BACK, 32'sd13, 6'd1));
            send_cmd(make_cmd(ple_pkg::FN_LIST, 32'sd0, 6'd0));
            send_cmd(make_cmd(ple_pkg::FN_DEL_POS, 32'sd0, 6'd33));
            send_cmd(make_cmd(ple_pkg::FN_DEL_POS, 32'sd0, 6'd32));
        end
        run_random(MIX_GROW, 10);
        run_random(MIX_BALANCED, 30);

        // Drain to empty, then keep pushing on the empty list.
        guard = 0;
        while (mirror.held() > 0 && guard < 300)
        begin
            send_cmd(random_cmd(MIX_SHRINK, mirror.held()));
            guard++;
        end
        run_random(MIX_SHRINK, 8);

        gaps_on = 1'b0;
        run_random(MIX_BALANCED, 20);
        gaps_on = 1'b1;
        run_random(MIX_BALANCED, 20);

        start <= 1'b0;
        while (mirror.owed() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mirror.errors == 0 && mirror.owed() == 0)
            $display("positional_list_engine_core regression: pass");
        else
            $display("positional_list_engine_core regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("positional_list_engine_core regression: fail");
        $finish;
    end

endmodule
